FILE: hw/rtl/source_text_tokenizer_core_defines.svh
// Assertion macros used by the tokenizer checker.
`ifndef SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define STT_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("tokenizer check failed");

// Next-cycle implication, sampled on clk, disabled during reset.
`define STT_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("tokenizer check failed");

`endif

FILE: hw/rtl/stt_pkg.sv
// Types, token codes and character helpers for the source text tokenizer.
package stt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_WORD,
        MODE_SYMBOL,
        MODE_COMMENT
    } scan_mode_t;

    localparam logic [5:0] TAG_OR       = 6'd0;
    localparam logic [5:0] TAG_AND      = 6'd1;
    localparam logic [5:0] TAG_EQ       = 6'd2;
    localparam logic [5:0] TAG_NE       = 6'd3;
    localparam logic [5:0] TAG_LE       = 6'd4;
    localparam logic [5:0] TAG_GE       = 6'd5;
    localparam logic [5:0] TAG_LT       = 6'd6;
    localparam logic [5:0] TAG_GT       = 6'd7;
    localparam logic [5:0] TAG_PLUS     = 6'd8;
    localparam logic [5:0] TAG_MINUS    = 6'd9;
    localparam logic [5:0] TAG_STAR     = 6'd10;
    localparam logic [5:0] TAG_SLASH    = 6'd11;
    localparam logic [5:0] TAG_PERCENT  = 6'd12;
    localparam logic [5:0] TAG_BANG     = 6'd13;
    localparam logic [5:0] TAG_AMP      = 6'd14;
    localparam logic [5:0] TAG_LPAREN   = 6'd15;
    localparam logic [5:0] TAG_RPAREN   = 6'd16;
    localparam logic [5:0] TAG_LBRACE   = 6'd17;
    localparam logic [5:0] TAG_RBRACE   = 6'd18;
    localparam logic [5:0] TAG_LBRACK   = 6'd19;
    localparam logic [5:0] TAG_RBRACK   = 6'd20;
    localparam logic [5:0] TAG_SEMI     = 6'd21;
    localparam logic [5:0] TAG_DOT      = 6'd22;
    localparam logic [5:0] TAG_COMMA    = 6'd23;
    localparam logic [5:0] TAG_ASSIGN   = 6'd24;
    localparam logic [5:0] TAG_DCOLON   = 6'd25;
    localparam logic [5:0] TAG_DEFINE   = 6'd26;
    localparam logic [5:0] TAG_ARROW    = 6'd27;
    localparam logic [5:0] TAG_IF       = 6'd28;
    localparam logic [5:0] TAG_THEN     = 6'd29;
    localparam logic [5:0] TAG_ELSE     = 6'd30;
    localparam logic [5:0] TAG_WHILE    = 6'd31;
    localparam logic [5:0] TAG_DO       = 6'd32;
    localparam logic [5:0] TAG_BREAK    = 6'd33;
    localparam logic [5:0] TAG_CONTINUE = 6'd34;
    localparam logic [5:0] TAG_RETURN   = 6'd35;
    localparam logic [5:0] TAG_CASE     = 6'd36;
    localparam logic [5:0] TAG_PROC     = 6'd37;
    localparam logic [5:0] TAG_STRUCT   = 6'd38;
    localparam logic [5:0] TAG_UNION    = 6'd39;
    localparam logic [5:0] TAG_ENUM     = 6'd40;
    localparam logic [5:0] TAG_ALIAS    = 6'd41;
    localparam logic [5:0] TAG_CAST     = 6'd42;
    localparam logic [5:0] TAG_VOID     = 6'd43;
    localparam logic [5:0] TAG_BOOL     = 6'd44;
    localparam logic [5:0] TAG_INT_TYPE = 6'd45;
    localparam logic [5:0] TAG_FALSE    = 6'd46;
    localparam logic [5:0] TAG_TRUE     = 6'd47;
    localparam logic [5:0] TAG_NULL     = 6'd48;
    localparam logic [5:0] TAG_INTEGER  = 6'd49;
    localparam logic [5:0] TAG_IDENT    = 6'd50;
    localparam logic [5:0] TAG_EOF      = 6'd51;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [5:0]  tag;
        logic [31:0] start;
        logic [15:0] length;
        logic [23:0] line;
        logic [15:0] column;
        logic        bad;
        logic        last;
    } token_t;

    // Up to two tokens handed from the scanner to the queue in the same cycle.
    typedef struct packed {
        logic   push0;
        logic   push1;
        token_t tok0;
        token_t tok1;
    } push_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic is_pendable(input logic [7:0] c);
        return (c == ":") || (c == "|") || (c == "/") || (c == "&") || (c == "=") ||
               (c == "!") || (c == "<") || (c == ">") || (c == "-");
    endfunction

    function automatic logic is_immediate(input logic [7:0] c);
        return (c == "+") || (c == "*") || (c == "%") || (c == "(") || (c == ")") ||
               (c == "{") || (c == "}") || (c == "[") || (c == "]") || (c == ";") ||
               (c == ".") || (c == ",");
    endfunction

    function automatic logic [5:0] immediate_tag(input logic [7:0] c);
        logic [5:0] t;
        unique case (c)
            "+":     t = TAG_PLUS;
            "*":     t = TAG_STAR;
            "%":     t = TAG_PERCENT;
            "(":     t = TAG_LPAREN;
            ")":     t = TAG_RPAREN;
            "{":     t = TAG_LBRACE;
            "}":     t = TAG_RBRACE;
            "[":     t = TAG_LBRACK;
            "]":     t = TAG_RBRACK;
            ";":     t = TAG_SEMI;
            ".":     t = TAG_DOT;
            ",":     t = TAG_COMMA;
            default: t = TAG_OR;
        endcase
        return t;
    endfunction

    // Key holds the first eight word characters, first one in the top byte, zero padded.
    function automatic logic [5:0] keyword_tag(input logic [63:0] key);
        logic [5:0] t;
        unique case (key)
            {"if", 48'd0}:     t = TAG_IF;
            {"then", 32'd0}:   t = TAG_THEN;
            {"else", 32'd0}:   t = TAG_ELSE;
            {"while", 24'd0}:  t = TAG_WHILE;
            {"do", 48'd0}:     t = TAG_DO;
            {"break", 24'd0}:  t = TAG_BREAK;
            {"continue"}:      t = TAG_CONTINUE;
            {"return", 16'd0}: t = TAG_RETURN;
            {"proc", 32'd0}:   t = TAG_PROC;
            {"case", 32'd0}:   t = TAG_CASE;
            {"struct", 16'd0}: t = TAG_STRUCT;
            {"union", 24'd0}:  t = TAG_UNION;
            {"enum", 32'd0}:   t = TAG_ENUM;
            {"alias", 24'd0}:  t = TAG_ALIAS;
            {"cast", 32'd0}:   t = TAG_CAST;
            {"void", 32'd0}:   t = TAG_VOID;
            {"bool", 32'd0}:   t = TAG_BOOL;
            {"false", 24'd0}:  t = TAG_FALSE;
            {"true", 32'd0}:   t = TAG_TRUE;
            {"null", 32'd0}:   t = TAG_NULL;
            default:           t = TAG_IDENT;
        endcase
        return t;
    endfunction

endpackage

FILE: hw/rtl/stt_front.sv
// Scanner front end: accepts bytes, tracks position and forms up to two tokens per byte.
module stt_front
    import stt_pkg::*;
#(
    parameter int KEYWORD_CHARS = 8,
    parameter int OFFSET_BITS   = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] source_byte,
    input  logic       space_ok,
    output push_t      push
);

    localparam int IDX_W = $clog2(KEYWORD_CHARS);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    scan_mode_t                         mode_reg, mode_next;
    logic [15:0]                        pend_reg, pend_next;
    logic [KEYWORD_CHARS-1:0][7:0]      word_reg, word_next;
    logic [15:0]                        len_reg, len_next;
    logic [OFFSET_BITS-1:0]             beg_off_reg, beg_off_next;
    logic [23:0]                        beg_line_reg, beg_line_next;
    logic [15:0]                        beg_col_reg, beg_col_next;
    logic [OFFSET_BITS-1:0]             cur_off_reg, cur_off_next;
    logic [23:0]                        cur_line_reg, cur_line_next;
    logic [15:0]                        cur_col_reg, cur_col_next;
    logic                               halted_reg, halted_next;

    logic        accept;
    logic        adv;
    logic        fresh;
    logic        r0_v, r0_bad, f_v, f_bad;
    logic [5:0]  r0_tag, f_tag, word_tag;
    logic [15:0] r0_len, f_len;
    logic [63:0] key;
    logic [7:0]  first_ch, second_ch, want_ch;
    logic [5:0]  pair_tag, single_tag;
    logic [7:0]  b;
    token_t      r0_tok, f_tok;

    assign b        = source_byte;
    assign in_ready = space_ok;
    assign accept   = in_valid && in_ready;
    assign first_ch  = pend_reg[7:0];
    assign second_ch = pend_reg[15:8];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            key[63 - 8*i -: 8] = word_reg[i];
        end
    end

    always_comb
    begin
        if (len_reg > 16'(KEYWORD_CHARS))
        begin
            word_tag = TAG_IDENT;
        end
        else if (((len_reg == 16'd2) || (len_reg == 16'd3)) &&
                 ((word_reg[0] == "i") || (word_reg[0] == "u")) && is_digit(word_reg[1]) &&
                 ((len_reg == 16'd2) || is_digit(word_reg[2])))
        begin
            word_tag = TAG_INT_TYPE;
        end
        else if (len_reg <= 16'd8)
        begin
            word_tag = keyword_tag(key);
        end
        else
        begin
            word_tag = TAG_IDENT;
        end
    end

    always_comb
    begin
        unique case (first_ch)
            "&":
            begin
                want_ch = "&"; pair_tag = TAG_AND; single_tag = TAG_AMP;
            end
            "=":
            begin
                want_ch = "="; pair_tag = TAG_EQ; single_tag = TAG_ASSIGN;
            end
            "!":
            begin
                want_ch = "="; pair_tag = TAG_NE; single_tag = TAG_BANG;
            end
            "<":
            begin
                want_ch = "="; pair_tag = TAG_LE; single_tag = TAG_LT;
            end
            ">":
            begin
                want_ch = "="; pair_tag = TAG_GE; single_tag = TAG_GT;
            end
            default:
            begin
                want_ch = ">"; pair_tag = TAG_ARROW; single_tag = TAG_MINUS;
            end
        endcase
    end

    always_comb
    begin
        mode_next     = mode_reg;
        pend_next     = pend_reg;
        word_next     = word_reg;
        len_next      = len_reg;
        beg_off_next  = beg_off_reg;
        beg_line_next = beg_line_reg;
        beg_col_next  = beg_col_reg;
        halted_next   = halted_reg;
        adv    = 1'b0;
        fresh  = 1'b0;
        r0_v   = 1'b0;
        r0_tag = TAG_OR;
        r0_len = 16'd0;
        r0_bad = 1'b0;
        f_v    = 1'b0;
        f_tag  = TAG_OR;
        f_len  = 16'd0;
        f_bad  = 1'b0;

        unique case (mode_reg)
            MODE_NUMBER:
            begin
                if (is_digit(b))
                begin
                    if (len_reg != 16'hFFFF) len_next = len_reg + 16'd1;
                    adv = 1'b1;
                end
                else
                begin
                    r0_v = 1'b1; r0_tag = TAG_INTEGER; r0_len = len_reg;
                    fresh = 1'b1;
                end
            end
            MODE_WORD:
            begin
                if (is_word_char(b))
                begin
                    if (len_reg < 16'(KEYWORD_CHARS)) word_next[len_reg[IDX_W-1:0]] = b;
                    if (len_reg != 16'hFFFF) len_next = len_reg + 16'd1;
                    adv = 1'b1;
                end
                else
                begin
                    r0_v = 1'b1; r0_tag = word_tag; r0_len = len_reg;
                    fresh = 1'b1;
                end
            end
            MODE_SYMBOL:
            begin
                if (first_ch == ":")
                begin
                    if (second_ch == ":")
                    begin
                        if (b == "=")
                        begin
                            r0_v = 1'b1; r0_tag = TAG_DEFINE; r0_len = 16'd3;
                            adv = 1'b1; mode_next = MODE_IDLE; pend_next = 16'd0;
                        end
                        else
                        begin
                            r0_v = 1'b1; r0_tag = TAG_DCOLON; r0_len = 16'd2;
                            fresh = 1'b1;
                        end
                    end
                    else if (b == ":")
                    begin
                        pend_next = {8'(":"), 8'(":")};
                        adv = 1'b1;
                    end
                    else
                    begin
                        r0_v = 1'b1; r0_len = 16'd1; r0_bad = 1'b1;
                        halted_next = 1'b1;
                    end
                end
                else if (first_ch == "|")
                begin
                    if (b == "|")
                    begin
                        r0_v = 1'b1; r0_tag = TAG_OR; r0_len = 16'd2;
                        adv = 1'b1; mode_next = MODE_IDLE; pend_next = 16'd0;
                    end
                    else
                    begin
                        r0_v = 1'b1; r0_len = 16'd1; r0_bad = 1'b1;
                        halted_next = 1'b1;
                    end
                end
                else if (first_ch == "/")
                begin
                    if (b == "/")
                    begin
                        mode_next = MODE_COMMENT; pend_next = 16'd0; adv = 1'b1;
                    end
                    else
                    begin
                        r0_v = 1'b1; r0_tag = TAG_SLASH; r0_len = 16'd1;
                        fresh = 1'b1;
                    end
                end
                else if (b == want_ch)
                begin
                    r0_v = 1'b1; r0_tag = pair_tag; r0_len = 16'd2;
                    adv = 1'b1; mode_next = MODE_IDLE; pend_next = 16'd0;
                end
                else
                begin
                    r0_v = 1'b1; r0_tag = single_tag; r0_len = 16'd1;
                    fresh = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (b == CH_NUL)
                begin
                    fresh = 1'b1;
                end
                else
                begin
                    adv = 1'b1;
                    if (b == CH_NEWLINE) mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        // A byte that ends a token, or arrives between tokens, starts a new scan.
        if (fresh)
        begin
            mode_next = MODE_IDLE;
            pend_next = 16'd0;
            if (is_space(b))
            begin
                adv = 1'b1;
            end
            else
            begin
                beg_off_next  = cur_off_reg;
                beg_line_next = cur_line_reg;
                beg_col_next  = cur_col_reg;
                if (b == CH_NUL)
                begin
                    f_v = 1'b1; f_tag = TAG_EOF;
                end
                else if (is_digit(b))
                begin
                    mode_next = MODE_NUMBER; len_next = 16'd1; adv = 1'b1;
                end
                else if (is_alpha(b) || (b == "_"))
                begin
                    mode_next = MODE_WORD;
                    word_next = '0;
                    word_next[0] = b;
                    len_next = 16'd1;
                    adv = 1'b1;
                end
                else if (is_pendable(b))
                begin
                    mode_next = MODE_SYMBOL; pend_next = {8'd0, b}; adv = 1'b1;
                end
                else if (is_immediate(b))
                begin
                    f_v = 1'b1; f_tag = immediate_tag(b); f_len = 16'd1; adv = 1'b1;
                end
                else
                begin
                    f_v = 1'b1; f_len = 16'd1; f_bad = 1'b1;
                    halted_next = 1'b1;
                end
            end
        end

        cur_off_next  = cur_off_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        if (adv)
        begin
            if (cur_off_reg != OFF_MAX) cur_off_next = cur_off_reg + OFFSET_BITS'(1);
            if (b == CH_NEWLINE)
            begin
                if (cur_line_reg != 24'hFFFFFF) cur_line_next = cur_line_reg + 24'd1;
                cur_col_next = 16'd1;
            end
            else if (cur_col_reg != 16'hFFFF)
            begin
                cur_col_next = cur_col_reg + 16'd1;
            end
        end
    end

    always_comb
    begin
        r0_tok.tag    = r0_tag;
        r0_tok.start  = 32'(beg_off_reg);
        r0_tok.length = r0_len;
        r0_tok.line   = beg_line_reg;
        r0_tok.column = beg_col_reg;
        r0_tok.bad    = r0_bad;
        r0_tok.last   = !f_v;

        f_tok.tag    = f_tag;
        f_tok.start  = 32'(cur_off_reg);
        f_tok.length = f_len;
        f_tok.line   = cur_line_reg;
        f_tok.column = cur_col_reg;
        f_tok.bad    = f_bad;
        f_tok.last   = 1'b1;

        push.push0 = accept && !halted_reg && (r0_v || f_v);
        push.push1 = accept && !halted_reg && r0_v && f_v;
        push.tok0  = r0_v ? r0_tok : f_tok;
        push.tok1  = f_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            pend_reg     <= 16'd0;
            word_reg     <= '0;
            len_reg      <= 16'd0;
            beg_off_reg  <= '0;
            beg_line_reg <= 24'd1;
            beg_col_reg  <= 16'd1;
            cur_off_reg  <= '0;
            cur_line_reg <= 24'd1;
            cur_col_reg  <= 16'd1;
            halted_reg   <= 1'b0;
        end
        else if (accept && !halted_reg)
        begin
            mode_reg     <= mode_next;
            pend_reg     <= pend_next;
            word_reg     <= word_next;
            len_reg      <= len_next;
            beg_off_reg  <= beg_off_next;
            beg_line_reg <= beg_line_next;
            beg_col_reg  <= beg_col_next;
            cur_off_reg  <= cur_off_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            halted_reg   <= halted_next;
        end
    end

endmodule

FILE: hw/rtl/stt_back.sv
// Token queue and output side: stores up to four tokens and presents the oldest.
module stt_back
    import stt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    output logic   space_ok,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t tok
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign tok       = mem[rd_ptr_reg];
    assign space_ok  = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.push0) + PTR_W'(push.push1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push0) mem[wr_ptr_reg] <= push.tok0;
        if (push.push1) mem[wr_ptr_reg + PTR_W'(1)] <= push.tok1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/source_text_tokenizer_core.sv
// Top level of the streaming source text tokenizer.
//
// The input channel (in_valid, in_ready, source_byte) takes one source byte per item;
// a zero byte marks the end of the source and yields an end token. The output channel
// (out_valid, out_ready and the token fields) delivers one token per item, in order.
// A byte gives zero, one or two tokens; last_of_run marks the final token of a byte.
// The scanner takes one byte per cycle while in_ready is high. A token is stored
// when the byte that completes it is accepted, and a second token from the same byte
// is stored behind it. Both results of a byte enter a four-entry token queue
// together, and in_ready is low while that queue holds more than two tokens, so
// sustained input is one byte per cycle for as long as the receiver keeps up.
// When the receiver stalls, the queue fills and in_ready drops; no token is lost.
// After an error token (bad_char high) the scanner keeps accepting bytes but gives
// no further tokens until reset. Reset empties the queue and returns the scanner to
// line 1, column 1, offset 0, between tokens.
module source_text_tokenizer_core
    import stt_pkg::*;
#(
    parameter int KEYWORD_CHARS = 8,
    parameter int OFFSET_BITS   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  source_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_tag,
    output logic [31:0] token_offset,
    output logic [15:0] token_length,
    output logic [23:0] token_line,
    output logic [15:0] token_column,
    output logic        bad_char,
    output logic        last_of_run
);

    push_t  push;
    logic   space_ok;
    token_t tok;

    // Front end: all lexing decisions and position tracking, a byte a cycle if ready.
    stt_front #(
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .source_byte (source_byte),
        .space_ok    (space_ok),
        .push        (push)
    );

    // Back end: the token queue decouples the scanner from a stalling receiver.
    stt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tok       (tok)
    );

    assign token_tag    = tok.tag;
    assign token_offset = tok.start;
    assign token_length = tok.length;
    assign token_line   = tok.line;
    assign token_column = tok.column;
    assign bad_char     = tok.bad;
    assign last_of_run  = tok.last;

endmodule

FILE: hw/rtl/stt_checker.sv
// Port-level checker for the tokenizer and its bind to the top level.
`include "source_text_tokenizer_core_defines.svh"

module stt_checker
    import stt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  source_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  token_tag,
    input logic [31:0] token_offset,
    input logic [15:0] token_length,
    input logic [23:0] token_line,
    input logic [15:0] token_column,
    input logic        bad_char,
    input logic        last_of_run
);

    // A stalled input item stays offered with the same byte.
    `STT_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(source_byte))

    // A stalled token stays offered at the same position.
    `STT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_offset))

    // An error token has tag zero, length one and is the last of its byte.
    `STT_ASSERT_NOW(a_bad_shape, out_valid && bad_char,
        token_tag == TAG_OR && token_length == 16'd1 && last_of_run)

    // An end token has zero length and closes its byte.
    `STT_ASSERT_NOW(a_eof_shape, out_valid && token_tag == TAG_EOF,
        token_length == 16'd0 && last_of_run && !bad_char)

    // Positions never report line or column zero.
    `STT_ASSERT_NOW(a_pos_nonzero, out_valid, token_line != 24'd0 && token_column != 16'd0)

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (.*);

FILE: sim/source_text_tokenizer_core_tb.sv
// Self-checking testbench for the streaming source text tokenizer core.
module source_text_tokenizer_core_tb;
    import stt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KW_CHARS = 8;
    localparam longint CYCLE_LIMIT = 400000;

    localparam logic [1:0] IDLE_NONE = 2'd0;
    localparam logic [1:0] IDLE_SEND = 2'd1;
    localparam logic [1:0] IDLE_RECV = 2'd2;
    localparam logic [1:0] IDLE_BOTH = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  source_byte;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  token_tag;
    logic [31:0] token_offset;
    logic [15:0] token_length;
    logic [23:0] token_line;
    logic [15:0] token_column;
    logic        bad_char;
    logic        last_of_run;

    source_text_tokenizer_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_byte  (source_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_tag    (token_tag),
        .token_offset (token_offset),
        .token_length (token_length),
        .token_line   (token_line),
        .token_column (token_column),
        .bad_char     (bad_char),
        .last_of_run  (last_of_run)
    );

    // Bytes waiting to be sent, and tokens the lexer model says must come out.
    logic [7:0] pending_bytes[$];
    token_t     expected_tokens[$];

    int         error_count = 0;
    longint     cycle_count = 0;
    logic [1:0] idle_phase = IDLE_NONE;
    logic       stimulus_done = 1'b0;

    // Shadow state of the lexer.
    scan_mode_t  lx_mode;
    logic [15:0] lx_pend;
    logic [7:0]  lx_word[KW_CHARS];
    logic [15:0] lx_wlen;
    logic [31:0] lx_beg_off;
    logic [23:0] lx_beg_line;
    logic [15:0] lx_beg_col;
    logic [31:0] lx_off;
    logic [23:0] lx_line;
    logic [15:0] lx_col;
    logic        lx_halted;
    token_t      byte_tokens[$];

    always #4 clk = ~clk;

    // Mismatch reporting: one line per failure, counted for the final verdict.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                 want);
    endtask

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_wordc(input logic [7:0] c);
        return is_letter(c) || is_dig(c) || c == "_";
    endfunction

    task automatic lexer_reset();
        lx_mode = MODE_IDLE;
        lx_pend = '0;
        for (int i = 0; i < KW_CHARS; i++) lx_word[i] = '0;
        lx_wlen = '0;
        lx_beg_off = '0;
        lx_beg_line = 24'd1;
        lx_beg_col = 16'd1;
        lx_off = '0;
        lx_line = 24'd1;
        lx_col = 16'd1;
        lx_halted = 1'b0;
    endtask

    task automatic step_position(input logic [7:0] c);
        if (lx_off != '1) lx_off++;
        if (c == CH_NEWLINE) begin
            if (lx_line != '1) lx_line++;
            lx_col = 16'd1;
        end
        else if (lx_col != '1) begin
            lx_col++;
        end
    endtask

    task automatic mark_start();
        lx_beg_off = lx_off;
        lx_beg_line = lx_line;
        lx_beg_col = lx_col;
    endtask

    task automatic add_token(input logic [5:0] tag, input logic [15:0] len,
                             input logic bad);
        token_t t;
        t.tag = tag;
        t.start = lx_beg_off;
        t.length = len;
        t.line = lx_beg_line;
        t.column = lx_beg_col;
        t.bad = bad;
        t.last = 1'b0;
        byte_tokens.push_back(t);
    endtask

    function automatic logic [5:0] word_kind();
        string s;
        logic [5:0] t;
        if (lx_wlen > KW_CHARS) return TAG_IDENT;
        if ((lx_wlen == 2 || lx_wlen == 3) && (lx_word[0] == "i" || lx_word[0] == "u")
            && is_dig(lx_word[1]) && (lx_wlen == 2 || is_dig(lx_word[2])))
            return TAG_INT_TYPE;
        s = "";
        for (int i = 0; i < lx_wlen; i++) s = {s, string'(lx_word[i])};
        case (s)
            "if":       t = TAG_IF;
            "then":     t = TAG_THEN;
            "else":     t = TAG_ELSE;
            "while":    t = TAG_WHILE;
            "do":       t = TAG_DO;
            "break":    t = TAG_BREAK;
            "continue": t = TAG_CONTINUE;
            "return":   t = TAG_RETURN;
            "proc":     t = TAG_PROC;
            "case":     t = TAG_CASE;
            "struct":   t = TAG_STRUCT;
            "union":    t = TAG_UNION;
            "enum":     t = TAG_ENUM;
            "alias":    t = TAG_ALIAS;
            "cast":     t = TAG_CAST;
            "void":     t = TAG_VOID;
            "bool":     t = TAG_BOOL;
            "false":    t = TAG_FALSE;
            "true":     t = TAG_TRUE;
            "null":     t = TAG_NULL;
            default:    t = TAG_IDENT;
        endcase
        return t;
    endfunction

    // Lexes a byte as the start of a new token.
    task automatic start_fresh(input logic [7:0] b);
        lx_mode = MODE_IDLE;
        lx_pend = '0;
        if (b == CH_NUL) begin
            mark_start();
            add_token(TAG_EOF, 16'd0, 1'b0);
        end
        else if (is_blank(b)) begin
            step_position(b);
        end
        else begin
            mark_start();
            if (is_dig(b)) begin
                lx_mode = MODE_NUMBER;
                lx_wlen = 16'd1;
                step_position(b);
            end
            else if (is_letter(b) || b == "_") begin
                lx_mode = MODE_WORD;
                for (int i = 0; i < KW_CHARS; i++) lx_word[i] = '0;
                lx_word[0] = b;
                lx_wlen = 16'd1;
                step_position(b);
            end
            else if (b == ":" || b == "|" || b == "/" || b == "&" || b == "=" || b == "!"
                     || b == "<" || b == ">" || b == "-") begin
                lx_mode = MODE_SYMBOL;
                lx_pend = {8'd0, b};
                step_position(b);
            end
            else begin
                logic [5:0] t;
                logic       known;
                known = 1'b1;
                case (b)
                    "+":     t = TAG_PLUS;
                    "*":     t = TAG_STAR;
                    "%":     t = TAG_PERCENT;
                    "(":     t = TAG_LPAREN;
                    ")":     t = TAG_RPAREN;
                    "{":     t = TAG_LBRACE;
                    "}":     t = TAG_RBRACE;
                    "[":     t = TAG_LBRACK;
                    "]":     t = TAG_RBRACK;
                    ";":     t = TAG_SEMI;
                    ".":     t = TAG_DOT;
                    ",":     t = TAG_COMMA;
                    default: begin t = TAG_OR; known = 1'b0; end
                endcase
                if (known) begin
                    add_token(t, 16'd1, 1'b0);
                    step_position(b);
                end
                else begin
                    add_token(TAG_OR, 16'd1, 1'b1);
                    lx_halted = 1'b1;
                end
            end
        end
    endtask

    task automatic finish_pair(input logic [5:0] tag, input logic [15:0] len,
                               input logic [7:0] b);
        add_token(tag, len, 1'b0);
        step_position(b);
        lx_mode = MODE_IDLE;
        lx_pend = '0;
    endtask

    // Resolves a pending operator character against the next byte.
    task automatic resolve_operator(input logic [7:0] b);
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] want;
        logic [5:0] pair;
        logic [5:0] single;
        first = lx_pend[7:0];
        second = lx_pend[15:8];
        if (first == ":") begin
            if (second == ":") begin
                if (b == "=") finish_pair(TAG_DEFINE, 16'd3, b);
                else begin
                    add_token(TAG_DCOLON, 16'd2, 1'b0);
                    start_fresh(b);
                end
            end
            else if (b == ":") begin
                lx_pend = {8'(":"), 8'(":")};
                step_position(b);
            end
            else begin
                add_token(TAG_OR, 16'd1, 1'b1);
                lx_halted = 1'b1;
            end
        end
        else if (first == "|") begin
            if (b == "|") finish_pair(TAG_OR, 16'd2, b);
            else begin
                add_token(TAG_OR, 16'd1, 1'b1);
                lx_halted = 1'b1;
            end
        end
        else if (first == "/") begin
            if (b == "/") begin
                lx_mode = MODE_COMMENT;
                lx_pend = '0;
                step_position(b);
            end
            else begin
                add_token(TAG_SLASH, 16'd1, 1'b0);
                start_fresh(b);
            end
        end
        else begin
            case (first)
                "&":     begin want = "&"; pair = TAG_AND; single = TAG_AMP;    end
                "=":     begin want = "="; pair = TAG_EQ;  single = TAG_ASSIGN; end
                "!":     begin want = "="; pair = TAG_NE;  single = TAG_BANG;   end
                "<":     begin want = "="; pair = TAG_LE;  single = TAG_LT;     end
                ">":     begin want = "="; pair = TAG_GE;  single = TAG_GT;     end
                default: begin want = ">"; pair = TAG_ARROW; single = TAG_MINUS; end
            endcase
            if (b == want) finish_pair(pair, 16'd2, b);
            else begin
                add_token(single, 16'd1, 1'b0);
                start_fresh(b);
            end
        end
    endtask

    // Feeds one accepted byte to the lexer model and queues the tokens it yields.
    task automatic predict_tokens(input logic [7:0] b);
        byte_tokens.delete();
        if (!lx_halted) begin
            case (lx_mode)
                MODE_NUMBER: begin
                    if (is_dig(b)) begin
                        if (lx_wlen != '1) lx_wlen++;
                        step_position(b);
                    end
                    else begin
                        add_token(TAG_INTEGER, lx_wlen, 1'b0);
                        start_fresh(b);
                    end
                end
                MODE_WORD: begin
                    if (is_wordc(b)) begin
                        if (lx_wlen < KW_CHARS) lx_word[lx_wlen] = b;
                        if (lx_wlen != '1) lx_wlen++;
                        step_position(b);
                    end
                    else begin
                        add_token(word_kind(), lx_wlen, 1'b0);
                        start_fresh(b);
                    end
                end
                MODE_SYMBOL: resolve_operator(b);
                MODE_COMMENT: begin
                    if (b == CH_NUL) start_fresh(b);
                    else begin
                        step_position(b);
                        if (b == CH_NEWLINE) lx_mode = MODE_IDLE;
                    end
                end
                default: start_fresh(b);
            endcase
        end
        if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
        foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
    endtask

    // Random well-formed fragment: keywords, names, numbers, operators, comments, whitespace.
    task automatic queue_fragment();
        string words[24];
        string ops[22];
        string s;
        int    n;
        words = '{"if", "then", "else", "while", "do", "break", "continue", "return",
                  "proc", "case", "struct", "union", "enum", "alias", "cast", "void",
                  "bool", "false", "true", "null", "i8", "u64", "x_1", "continues"};
        ops = '{"::=", "::", "->", "-", "==", "=", "!=", "!", "<=", "<", ">=", ">", "&&",
                "&", "||", "/", "+", "*", "%", "(", ")", ";"};
        case ($urandom_range(0, 9))
            0, 1, 2: queue_text(words[$urandom_range(0, 23)]);
            3: begin
                s = "";
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(0, 2) == 0 ? "_" :
                                       ($urandom_range(0, 1) ? $urandom_range("a", "z")
                                                             : $urandom_range("A", "Z"))))};
                queue_text(s);
            end
            4: begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++) pending_bytes.push_back(8'($urandom_range("0", "9")));
            end
            5, 6: queue_text(ops[$urandom_range(0, 21)]);
            7: queue_text("// note\n");
            default: begin
                n = $urandom_range(0, 5);
                pending_bytes.push_back($urandom_range(0, 1) ? " " : CH_NEWLINE);
                for (int i = 0; i < n; i++) pending_bytes.push_back(8'($urandom_range(9, 13)));
            end
        endcase
        if ($urandom_range(0, 2) == 0) pending_bytes.push_back(" ");
    endtask

    // Waits until every queued byte is sent and every token has come back.
    task automatic drain();
        while (pending_bytes.size() > 0 || in_valid || expected_tokens.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // A bad byte halts the block, so reset would be needed; reset is asserted only once,
    // so every error case is saved for the last segment of the run.
    initial begin
        int sent;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        source_byte = '0;
        out_ready = 1'b0;
        lexer_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: operators, keywords, type names, numbers, names, a comment and end markers.
        queue_text("i8 u16 continue 0 65535 ::= :: -> <= >= == != && || a/b //c\n");
        queue_text("+*%(){}[];., ! & < > = - _Z9");
        pending_bytes.push_back(CH_NUL);
        pending_bytes.push_back(CH_NUL);
        queue_text("i999 x//z");
        pending_bytes.push_back(CH_NUL);
        drain();

        // Random part, stepping through the idle phases.
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            idle_phase = 2'(ph);
            while (sent < (ph + 1) * 480) begin
                int before_size;
                before_size = pending_bytes.size();
                if ($urandom_range(0, 60) == 0) pending_bytes.push_back(CH_NUL);
                else if ($urandom_range(0, 40) == 0) begin
                    // Bytes that are harmless anywhere: a letter or a digit.
                    pending_bytes.push_back(8'($urandom_range(0, 1) ? "7" : "Q"));
                end
                else queue_fragment();
                sent += pending_bytes.size() - before_size;
                if (pending_bytes.size() > 64) wait (pending_bytes.size() < 16);
            end
            drain();
        end

        // Final segment: one well-formed run, then an unknown byte with the high bit set
        // (all bits set), and noise that must give no tokens after the halt.
        idle_phase = IDLE_BOTH;
        queue_text("abc ");
        pending_bytes.push_back(8'hFF);
        for (int i = 0; i < 20; i++) pending_bytes.push_back(8'($urandom_range(0, 255)));
        drain();
        stimulus_done = 1'b1;
    end

    // Driver: presents the oldest pending byte and holds it until accepted.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) predict_tokens(source_byte);
            if (!in_valid || in_ready) begin
                if (pending_bytes.size() > 0 &&
                    !(idle_phase[0] && $urandom_range(0, 99) < 55 + (idle_phase == IDLE_BOTH ? -42 : 0))) begin
                    in_valid <= 1'b1;
                    source_byte <= pending_bytes.pop_front();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
            if (idle_phase[1])
                out_ready <= $urandom_range(0, 99) >= (idle_phase == IDLE_BOTH ? 13 : 55);
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: checks each delivered token against the oldest expectation.
    always @(posedge clk) begin
        cycle_count++;
        if (rst_n && out_valid && out_ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("unexpected token, tag", token_tag, 0);
            end
            else begin
                token_t want;
                want = expected_tokens.pop_front();
                if (token_tag !== want.tag) report_mismatch("token_tag", token_tag, want.tag);
                if (token_offset !== want.start)
                    report_mismatch("token_offset", token_offset, want.start);
                if (token_length !== want.length)
                    report_mismatch("token_length", token_length, want.length);
                if (token_line !== want.line) report_mismatch("token_line", token_line, want.line);
                if (token_column !== want.column)
                    report_mismatch("token_column", token_column, want.column);
                if (bad_char !== want.bad) report_mismatch("bad_char", bad_char, want.bad);
                if (last_of_run !== want.last)
                    report_mismatch("last_of_run", last_of_run, want.last);
            end
        end
    end

    // Verdict, or a timeout if the run hangs.
    always @(posedge clk) begin
        if (stimulus_done) begin
            if (error_count == 0 && expected_tokens.size() == 0) $display("source_text_tokenizer_core_tb OK");
            else $display("source_text_tokenizer_core_tb NOT OK");
            $finish;
        end
        else if (cycle_count > CYCLE_LIMIT) begin
            $display("source_text_tokenizer_core_tb NOT OK");
            $finish;
        end
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/stt_pkg.sv
hw/rtl/stt_front.sv
hw/rtl/stt_back.sv
hw/rtl/source_text_tokenizer_core.sv
hw/rtl/stt_checker.sv
sim/source_text_tokenizer_core_tb.sv
